// ===== sv/ebb_pkg.sv =====
// ebb_pkg: shared types, constants and helper functions of the elastic ball box step
// used by elastic_ball_box_step; no dependencies
package ebb_pkg;

   // number of ball slots in the stores
   localparam int MAX_BALLS  = 16;
   localparam int IDX_W      = $clog2(MAX_BALLS);
   // balls in use never exceed the slots nor the 16 result slots
   localparam int BALL_LIMIT = (MAX_BALLS < 16) ? MAX_BALLS : 16;

   // configuration register indexes
   localparam logic [1:0] REG_BALL_COUNT = 2'd0;
   localparam logic [1:0] REG_BOX_LENGTH = 2'd1;
   localparam logic [1:0] REG_TIME_STEP  = 2'd2;

   // reset values of the registers
   localparam logic [4:0]  BALL_COUNT_RST = 5'd2;
   localparam logic [30:0] BOX_LENGTH_RST = 31'd131072;
   localparam logic [31:0] TIME_STEP_RST  = 32'd4294967;

   // action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   // saturation bounds at the wide intermediate width
   localparam logic signed [66:0] SAT_MAX = 67'sd2147483647;
   localparam logic signed [66:0] SAT_MIN = -67'sd2147483648;

   typedef struct packed {
      logic               action;
      logic [3:0]         ball_index;
      logic signed [31:0] load_position;
      logic signed [31:0] load_velocity;
      logic [31:0]        load_mass;
      logic [30:0]        load_radius;
   } req_type;

   typedef struct packed {
      logic [3:0]         out_index;
      logic signed [31:0] out_position;
      logic signed [31:0] out_velocity;
      logic               any_collision;
      logic               last_ball;
   } rsp_type;

   // clamp a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // magnitude of a signed 32-bit value
   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

   // sign extension to the wide intermediate width
   function automatic logic signed [66:0] sext67(input logic signed [31:0] v);
      logic signed [66:0] r;
      r = {{35{v[31]}}, v};
      return r;
   endfunction

endpackage

// ===== sv/elastic_ball_box_step.sv =====
// elastic_ball_box_step: top level of the one-dimensional elastic ball box
// depends on ebb_pkg and ebb_ram
//
// Usage: the req_ channel takes one item at a time. A load item (action 0)
// writes one ball into the position, velocity, mass and radius memories and
// gives no result. A step item (action 1) advances every ball in use,
// resolves overlapping pairs i<j in order, bounces balls off the walls and
// then sends one rsp_ item per ball in use, in index order, with last_ball
// set on the final one. req_stall is high while a step is at work. Each
// overlapping pair with a nonzero mass sum is resolved with the 32x32
// multiplier, which the advance shares, and the bit-serial divider, which
// makes one quotient bit a cycle.
// A ball count of zero makes a step that changes nothing and sends nothing.
// Results leave through an output register; while rsp_stall is high the
// result holds and the sequencer waits, and the next item may be taken while
// the final result still waits. Reset clears the sequencer and the output
// valid and loads the register defaults; the ball memories are not cleared.
// The csr_ port writes ball_count, box_length or time_step.
module elastic_ball_box_step (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ebb_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output ebb_pkg::rsp_type rsp_data,
   input  logic            csr_write,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_data
);

   typedef enum logic [16:0] {
      ST_IDLE    = 17'b00000000000000001,
      ST_ADV_RD  = 17'b00000000000000010,
      ST_ADV_MUL = 17'b00000000000000100,
      ST_ADV_WR  = 17'b00000000000001000,
      ST_PR_I    = 17'b00000000000010000,
      ST_PR_J    = 17'b00000000000100000,
      ST_PR_CHK  = 17'b00000000001000000,
      ST_MUL_A   = 17'b00000000010000000,
      ST_MUL_B   = 17'b00000000100000000,
      ST_DIV_SET = 17'b00000001000000000,
      ST_DIV     = 17'b00000010000000000,
      ST_UPD_I   = 17'b00000100000000000,
      ST_UPD_J   = 17'b00001000000000000,
      ST_WALL_RD = 17'b00010000000000000,
      ST_WALL_WR = 17'b00100000000000000,
      ST_OUT_RD  = 17'b01000000000000000,
      ST_OUT_LD  = 17'b10000000000000000
   } state_type;

   localparam int IW = ebb_pkg::IDX_W;

   // control state
   state_type      state_ff, state_in;
   logic [IW-1:0]  i_ff, i_in, j_ff, j_in;
   logic [4:0]     n_ff, n_in;
   logic           hit_ff, hit_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [4:0]     count_ff, count_in;
   logic [30:0]    box_ff, box_in;
   logic [31:0]    dt_ff, dt_in;

   // datapath registers
   logic signed [31:0] xi_ff, vi_ff, vj_ff;
   logic [31:0]        mi_ff, mj_ff;
   logic [30:0]        ri_ff;
   logic               neg_ff;
   logic [63:0]        prod_ff, a_ff, lo_ff, q_ff;
   logic [33:0]        rem_ff;
   logic [32:0]        den_ff;
   logic [5:0]         cnt_ff;
   logic               zneg_ff;
   ebb_pkg::rsp_type   rsp_ff;

   // memory ports
   logic [IW-1:0]  wr_addr, rd_addr;
   logic           pos_we, vel_we, load_we;
   logic [31:0]    pos_wd, vel_wd;
   logic [31:0]    pos_rd, vel_rd, mass_rd;
   logic [30:0]    rad_rd;

   // handshakes
   logic req_acc, is_load, idx_ok, can_load;
   logic [4:0] n_req;

   // loop position
   logic last_i, last_j, pair_done;

   // shared multiplier
   logic [31:0] mul_x, mul_y;
   logic [63:0] mul_p;

   // advance
   logic [64:0]        rnd;
   logic [32:0]        delta_mag;
   logic signed [66:0] delta, adv_wide;

   // overlap test
   logic signed [32:0] diff;
   logic [32:0]        dabs;
   logic [31:0]        reach;
   logic               overlap, mass_nz;

   // divider set-up and step
   logic [64:0]  sum65;
   logic         same_sign, a_ge;
   logic [63:0]  lo0;
   logic         hi0, zneg0;
   logic [32:0]  den0;
   logic [33:0]  rem0, t, rem_step;
   logic         q_bit;

   // velocity update
   logic signed [66:0] vz, two_vz;
   logic signed [31:0] new_vi, new_vj;

   // walls
   logic               wall_lo, wall_hi, bounce;
   logic signed [33:0] room;
   logic signed [31:0] neg_v;

   // ball memories
   ebb_ram #(.WIDTH(32), .DEPTH(ebb_pkg::MAX_BALLS)) u_pos_ram (
      .clock(clock), .wr_en(pos_we), .wr_addr(wr_addr), .wr_data(pos_wd),
      .rd_addr(rd_addr), .rd_data(pos_rd));
   ebb_ram #(.WIDTH(32), .DEPTH(ebb_pkg::MAX_BALLS)) u_vel_ram (
      .clock(clock), .wr_en(vel_we), .wr_addr(wr_addr), .wr_data(vel_wd),
      .rd_addr(rd_addr), .rd_data(vel_rd));
   ebb_ram #(.WIDTH(32), .DEPTH(ebb_pkg::MAX_BALLS)) u_mass_ram (
      .clock(clock), .wr_en(load_we), .wr_addr(wr_addr), .wr_data(req_data.load_mass),
      .rd_addr(rd_addr), .rd_data(mass_rd));
   ebb_ram #(.WIDTH(31), .DEPTH(ebb_pkg::MAX_BALLS)) u_rad_ram (
      .clock(clock), .wr_en(load_we), .wr_addr(wr_addr), .wr_data(req_data.load_radius),
      .rd_addr(rd_addr), .rd_data(rad_rd));

   // handshake and item decode
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign is_load   = (req_data.action == ebb_pkg::ACT_LOAD);
   assign idx_ok    = (32'(req_data.ball_index) < 32'(ebb_pkg::MAX_BALLS));
   assign load_we   = req_acc && is_load && idx_ok;
   assign n_req     = (32'(count_ff) > 32'(ebb_pkg::BALL_LIMIT)) ?
                      5'(ebb_pkg::BALL_LIMIT) : count_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign can_load  = !rsp_valid_ff || !rsp_stall;

   // loop position flags
   assign last_i    = (5'(i_ff) == n_ff - 5'd1);
   assign last_j    = (5'(j_ff) == n_ff - 5'd1);
   assign pair_done = last_j && (5'(i_ff) == n_ff - 5'd2);

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_MUL_A: begin
            mul_x = ebb_pkg::abs32(vi_ff);
            mul_y = mi_ff;
         end
         ST_MUL_B: begin
            mul_x = ebb_pkg::abs32(vj_ff);
            mul_y = mj_ff;
         end
         default: begin
            mul_x = ebb_pkg::abs32(vel_rd);
            mul_y = dt_ff;
         end
      endcase
   end
   assign mul_p = 64'(mul_x) * 64'(mul_y);

   // advance: floor of v*dt over 2^32, added with saturation
   assign rnd       = {1'b0, prod_ff} + 65'h0_FFFF_FFFF;
   assign delta_mag = neg_ff ? rnd[64:32] : {1'b0, prod_ff[63:32]};
   assign delta     = $signed({34'b0, delta_mag});
   assign adv_wide  = ebb_pkg::sext67(xi_ff) + (neg_ff ? -delta : delta);

   // overlap test of the current pair
   assign diff    = $signed({xi_ff[31], xi_ff}) - $signed({pos_rd[31], pos_rd});
   assign dabs    = diff[32] ? 33'(-diff) : 33'(diff);
   assign reach   = {1'b0, ri_ff} + {1'b0, rad_rd};
   assign overlap = dabs < {1'b0, reach};
   assign mass_nz = ({1'b0, mi_ff} + {1'b0, mass_rd}) != 33'd0;

   // divider set-up: signed momentum sum over the mass sum
   assign sum65     = {1'b0, a_ff} + {1'b0, prod_ff};
   assign same_sign = (vi_ff[31] == vj_ff[31]);
   assign a_ge      = a_ff >= prod_ff;
   assign lo0       = same_sign ? sum65[63:0] : (a_ge ? a_ff - prod_ff : prod_ff - a_ff);
   assign hi0       = same_sign ? sum65[64] : 1'b0;
   assign zneg0     = same_sign ? vi_ff[31] : (a_ge ? vi_ff[31] : vj_ff[31]);
   assign den0      = {1'b0, mi_ff} + {1'b0, mj_ff};
   assign rem0      = (34'(hi0) >= {1'b0, den0}) ? 34'(hi0) - {1'b0, den0} : 34'(hi0);

   // one restoring division step
   assign t        = {rem_ff[32:0], lo_ff[63]};
   assign q_bit    = t >= {1'b0, den_ff};
   assign rem_step = q_bit ? t - {1'b0, den_ff} : t;

   // reflected velocities
   assign vz     = zneg_ff ? -$signed({3'b0, q_ff}) : $signed({3'b0, q_ff});
   assign two_vz = vz <<< 1;
   assign new_vi = ebb_pkg::sat32(two_vz - ebb_pkg::sext67(vi_ff));
   assign new_vj = ebb_pkg::sat32(two_vz - ebb_pkg::sext67(vj_ff));

   // wall test
   assign wall_lo = $signed({pos_rd[31], pos_rd}) < $signed({2'b0, rad_rd});
   assign room    = $signed({3'b0, box_ff}) - $signed({{2{pos_rd[31]}}, pos_rd});
   assign wall_hi = room < $signed({3'b0, rad_rd});
   assign bounce  = wall_lo || wall_hi;
   assign neg_v   = ebb_pkg::sat32(-ebb_pkg::sext67(vel_rd));

   // memory addresses and write data
   always_comb begin
      rd_addr = (state_ff == ST_PR_J) ? j_ff : i_ff;
      if (state_ff == ST_IDLE) begin
         wr_addr = IW'(req_data.ball_index);
      end else if (state_ff == ST_UPD_J) begin
         wr_addr = j_ff;
      end else begin
         wr_addr = i_ff;
      end
      pos_we = load_we || (state_ff == ST_ADV_WR);
      pos_wd = (state_ff == ST_IDLE) ? req_data.load_position : ebb_pkg::sat32(adv_wide);
      vel_we = load_we || (state_ff == ST_UPD_I) || (state_ff == ST_UPD_J) ||
               ((state_ff == ST_WALL_WR) && bounce);
      unique case (state_ff)
         ST_UPD_I:   vel_wd = new_vi;
         ST_UPD_J:   vel_wd = new_vj;
         ST_WALL_WR: vel_wd = neg_v;
         default:    vel_wd = req_data.load_velocity;
      endcase
   end

   // configuration writes
   always_comb begin
      count_in = count_ff;
      box_in   = box_ff;
      dt_in    = dt_ff;
      if (csr_write) begin
         unique case (csr_index)
            ebb_pkg::REG_BALL_COUNT: count_in = csr_data[4:0];
            ebb_pkg::REG_BOX_LENGTH: box_in   = csr_data[30:0];
            ebb_pkg::REG_TIME_STEP:  dt_in    = csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && !is_load && (n_req != 5'd0)) begin
               n_in     = n_req;
               i_in     = '0;
               hit_in   = 1'b0;
               state_in = ST_ADV_RD;
            end
         end
         ST_ADV_RD:  state_in = ST_ADV_MUL;
         ST_ADV_MUL: state_in = ST_ADV_WR;
         ST_ADV_WR: begin
            if (!last_i) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_ADV_RD;
            end else if (n_ff == 5'd1) begin
               i_in     = '0;
               state_in = ST_WALL_RD;
            end else begin
               i_in     = '0;
               j_in     = IW'(1);
               state_in = ST_PR_I;
            end
         end
         ST_PR_I: state_in = ST_PR_J;
         ST_PR_J: state_in = ST_PR_CHK;
         ST_PR_CHK, ST_UPD_J: begin
            if ((state_ff == ST_PR_CHK) && overlap) begin
               hit_in = 1'b1;
            end
            if ((state_ff == ST_PR_CHK) && overlap && mass_nz) begin
               state_in = ST_MUL_A;
            end else if (pair_done) begin
               i_in     = '0;
               state_in = ST_WALL_RD;
            end else if (last_j) begin
               i_in     = i_ff + 1'b1;
               j_in     = i_ff + IW'(2);
               state_in = ST_PR_I;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_PR_I;
            end
         end
         ST_MUL_A:   state_in = ST_MUL_B;
         ST_MUL_B:   state_in = ST_DIV_SET;
         ST_DIV_SET: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == 6'd0) begin
               state_in = ST_UPD_I;
            end
         end
         ST_UPD_I:   state_in = ST_UPD_J;
         ST_WALL_RD: state_in = ST_WALL_WR;
         ST_WALL_WR: begin
            if (last_i) begin
               i_in     = '0;
               state_in = ST_OUT_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_WALL_RD;
            end
         end
         ST_OUT_RD: state_in = ST_OUT_LD;
         ST_OUT_LD: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               if (last_i) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= ebb_pkg::BALL_COUNT_RST;
         box_ff       <= ebb_pkg::BOX_LENGTH_RST;
         dt_ff        <= ebb_pkg::TIME_STEP_RST;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         box_ff       <= box_in;
         dt_ff        <= dt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_ADV_MUL) begin
         xi_ff  <= pos_rd;
         neg_ff <= vel_rd[31];
      end
      if ((state_ff == ST_ADV_MUL) || (state_ff == ST_MUL_A) || (state_ff == ST_MUL_B)) begin
         prod_ff <= mul_p;
      end
      if (state_ff == ST_MUL_B) begin
         a_ff <= prod_ff;
      end
      if (state_ff == ST_PR_J) begin
         xi_ff <= pos_rd;
         vi_ff <= vel_rd;
         mi_ff <= mass_rd;
         ri_ff <= rad_rd;
      end
      if (state_ff == ST_PR_CHK) begin
         vj_ff <= vel_rd;
         mj_ff <= mass_rd;
      end
      if (state_ff == ST_DIV_SET) begin
         lo_ff   <= lo0;
         rem_ff  <= rem0;
         den_ff  <= den0;
         zneg_ff <= zneg0;
         q_ff    <= '0;
         cnt_ff  <= 6'd63;
      end
      if (state_ff == ST_DIV) begin
         rem_ff <= rem_step;
         lo_ff  <= {lo_ff[62:0], 1'b0};
         q_ff   <= {q_ff[62:0], q_bit};
         cnt_ff <= cnt_ff - 6'd1;
      end
      if ((state_ff == ST_OUT_LD) && can_load) begin
         rsp_ff.out_index     <= 4'(i_ff);
         rsp_ff.out_position  <= pos_rd;
         rsp_ff.out_velocity  <= vel_rd;
         rsp_ff.any_collision <= hit_ff;
         rsp_ff.last_ball     <= last_i;
      end
   end

   // remainder stays below the divisor throughout the division
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < {1'b0, den_ff}))
      else $error("division remainder not below divisor");

   // a pair under test always has j above i and inside the balls in use
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PR_CHK) |-> ((j_ff > i_ff) && (5'(j_ff) < n_ff)))
      else $error("pair indexes out of order");

   // advance writes only balls in use
   a_adv_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV_WR) |-> (5'(i_ff) < n_ff))
      else $error("advance beyond balls in use");

   // a result is loaded only when the output register is free or leaving
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("pending item overwritten");

endmodule

// ===== sv/ebb_ram.sv =====
// ebb_ram: generic single write port memory with one registered read port
// no dependencies
module ebb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
